// ===== hdl/nc_pkg.sv =====
package nc_pkg;

	localparam int unsigned ENTRIES_DEF = 32;
	localparam logic [31:0] CACHE_TO_RST = 32'd3600000;
	localparam logic [31:0] FREEZE_TO_RST = 32'd1800000;
	localparam logic [31:0] REPLY_TO_RST = 32'd1000;
	localparam logic [2:0] MAX_ATT_RST = 3'd3;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0,
		ACT_REQUEST = 3'd1,
		ACT_CHECK = 3'd2,
		ACT_ADD = 3'd3,
		ACT_SERVICE = 3'd4,
		ACT_READ = 3'd5,
		ACT_NOP6 = 3'd6,
		ACT_NOP7 = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_WANT = 2'd1,
		ST_SENT = 2'd2,
		ST_VALID = 2'd3
	} est_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RD,
		S_WAIT,
		S_EXEC,
		S_OUT
	} bst_t;

	typedef enum logic [1:0] {
		REG_CACHE = 2'd0,
		REG_FREEZE = 2'd1,
		REG_REPLY = 2'd2,
		REG_MAXATT = 2'd3
	} reg_t;

	typedef struct packed {
		act_t        act;
		logic        blank;
		logic        mac_zero;
		logic [63:0] ip_high;
		logic [63:0] ip_low;
		logic [47:0] mac;
		logic [4:0]  idx;
		logic [31:0] now;
		logic        busy;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic        found;
		logic [47:0] mac_out;
		logic [4:0]  index_out;
		logic [1:0]  state_out;
		logic [31:0] age_out;
		logic        send_request;
		logic [63:0] addr_high_out;
		logic [63:0] addr_low_out;
	} res_t;

endpackage

// ===== hdl/ipv6_neighbor_cache.sv =====
// Neighbor cache of ENTRIES records mapping IPv6 addresses to MACs. Words
// enter a two-deep queue and are carried out one at a time; each word scans
// every record through the single read port of the record memory, one
// record per cycle, then reads one record and, where its action calls for
// it, updates and writes it back. The next word is not taken from the queue
// until the result word of the last one has been accepted. Exactly one
// result word leaves per input word.
module ipv6_neighbor_cache
	import nc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action, ip_high, ip_low, mac_in, entry_index, now_ms, resolver_busy
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, found, mac_out, index_out, state_out, age_out, send_request,
	// addr_high_out, addr_low_out
	output logic [223:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_data
);

	logic q_valid, q_ready;
	cmd_t q_cmd;
	res_t r;

	nc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	nc_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_res(r),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	assign m_axis_tdata = {6'd0, r.addr_low_out, r.addr_high_out, r.send_request,
		r.age_out, r.state_out, r.index_out, r.mac_out, r.found, r.status};

endmodule

// ===== hdl/nc_ram.sv =====
module nc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/nc_front.sv =====
module nc_front
	import nc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,
	output logic         q_valid,
	input  logic         q_ready,
	output cmd_t         q_cmd
);

	// two-entry queue
	cmd_t       buf_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	cmd_t       c;
	logic       push;
	logic       pop;

	always_comb begin
		c.act = act_t'(s_tdata[2:0]);
		c.ip_high = s_tdata[66:3];
		c.ip_low = s_tdata[130:67];
		c.mac = s_tdata[178:131];
		c.idx = s_tdata[183:179];
		c.now = s_tdata[215:184];
		c.busy = s_tdata[216];
		c.blank = (s_tdata[66:59] == 8'd0);
		c.mac_zero = (s_tdata[178:131] == 48'd0);
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_pop_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");
`endif

endmodule

// ===== hdl/nc_back.sv =====
module nc_back
	import nc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  cmd_t        q_cmd,
	output logic        r_valid,
	input  logic        r_ready,
	output res_t        r_res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = 64 + 64 + 48 + 3 + 32;
	localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	logic [31:0] cache_to_q;
	logic [31:0] freeze_to_q;
	logic [31:0] reply_to_q;
	logic [2:0]  max_att_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_to_q <= CACHE_TO_RST;
			freeze_to_q <= FREEZE_TO_RST;
			reply_to_q <= REPLY_TO_RST;
			max_att_q <= MAX_ATT_RST;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_idx))
				REG_CACHE:  cache_to_q <= cfg_data;
				REG_FREEZE: freeze_to_q <= cfg_data;
				REG_REPLY:  reply_to_q <= cfg_data;
				REG_MAXATT: max_att_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// status bits in flops, record payload in ram
	logic [1:0] est_q [ENTRIES];
	logic           ram_we;
	logic [IW-1:0]  ram_wa;
	logic [RW-1:0]  ram_wd;
	logic [IW-1:0]  ram_ra;
	logic [RW-1:0]  ram_rd;

	nc_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [63:0] rd_hi, rd_lo;
	logic [47:0] rd_mac;
	logic [2:0]  rd_tries;
	logic [31:0] rd_stamp;
	assign {rd_hi, rd_lo, rd_mac, rd_tries, rd_stamp} = ram_rd;

	bst_t        st_q, st_d;
	cmd_t        cmd_q;
	logic [CW-1:0] k_q;
	logic [IW-1:0] kd_q;
	logic        kv_q;
	logic        hit_q, hitv_q;
	logic [IW-1:0] hidx_q, vhidx_q;
	logic        emp_q;
	logic [IW-1:0] eidx_q;
	logic [31:0] bage_q;
	logic [IW-1:0] bidx_q;
	logic [IW-1:0] sp_q;
	logic [IW-1:0] tgt_q;
	res_t        res_q;
	logic        rv_q;

	logic blank_req;
	assign blank_req = cmd_q.blank;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (q_valid && !rv_q) begin
				st_d = S_SCAN;
			end
			S_SCAN: if (k_q == ENT_C && !kv_q) begin
				st_d = S_RD;
			end
			S_RD:   st_d = S_WAIT;
			S_WAIT: st_d = S_EXEC;
			S_EXEC: st_d = S_OUT;
			S_OUT:  st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// scan compare on the registered read of entry kd_q
	logic [1:0]  ks;
	logic        amatch;
	logic [31:0] kage;
	assign ks = est_q[kd_q];
	assign amatch = (rd_hi == cmd_q.ip_high) && (rd_lo == cmd_q.ip_low);
	assign kage = cmd_q.now - rd_stamp;

	// target entry stays addressed from the read through the write back
	logic use_scan;
	always_comb begin
		use_scan = (st_q == S_SCAN);
		ram_ra = tgt_q;
		if (st_q == S_SCAN) begin
			ram_ra = k_q[IW-1:0];
		end
	end

	// target decision at end of scan
	logic [IW-1:0] victim;
	assign victim = emp_q ? eidx_q : bidx_q;
	logic [IW-1:0] sp_next;
	assign sp_next = (sp_q == LAST) ? '0 : sp_q + 1'b1;
	logic [IW-1:0] tgt_d;

	always_comb begin
		logic [IW-1:0] t;
		t = hit_q ? hidx_q : victim;
		unique case (cmd_q.act)
			ACT_LOOKUP, ACT_CHECK: t = hitv_q ? vhidx_q : (hit_q ? hidx_q : victim);
			ACT_SERVICE: t = sp_next;
			ACT_READ: t = IW'(cmd_q.idx);
			default: ;
		endcase
		tgt_d = t;
	end

	// execute on entry tgt_q with ram data
	logic        e_we;
	logic [1:0]  e_st;
	logic [63:0] e_hi, e_lo;
	logic [47:0] e_mac;
	logic [2:0]  e_tries;
	logic [31:0] e_stamp;
	res_t        e_res;
	logic        e_sp;
	logic        idx_ok;

	always_comb begin
		logic [1:0]  s;
		logic [31:0] age;
		logic        req;
		s = est_q[tgt_q];
		age = cmd_q.now - rd_stamp;
		e_we = 1'b0;
		e_st = s;
		e_hi = rd_hi;
		e_lo = rd_lo;
		e_mac = rd_mac;
		e_tries = rd_tries;
		e_stamp = rd_stamp;
		e_res = '0;
		e_sp = 1'b0;
		req = 1'b0;
		idx_ok = ({{(32-5){1'b0}}, cmd_q.idx} < 32'(ENTRIES));
		case (cmd_q.act)
			ACT_LOOKUP, ACT_CHECK: begin
				if (hitv_q) begin
					e_res.found = 1'b1;
					e_res.mac_out = rd_mac;
					e_res.index_out = 5'(tgt_q);
				end else if (cmd_q.act == ACT_CHECK) begin
					req = 1'b1;
				end
			end
			ACT_REQUEST: req = 1'b1;
			ACT_ADD: begin
				if (cmd_q.blank || cmd_q.mac_zero) begin
					e_res.status = 1'b1;
				end else begin
					e_we = 1'b1;
					if (!hit_q) begin
						e_hi = cmd_q.ip_high;
						e_lo = cmd_q.ip_low;
					end
					e_mac = cmd_q.mac;
					e_stamp = cmd_q.now;
					e_st = ST_VALID;
					e_res.index_out = 5'(tgt_q);
				end
			end
			ACT_SERVICE: begin
				e_sp = 1'b1;
				e_we = 1'b1;
				e_res.index_out = 5'(tgt_q);
				if (e_st != ST_EMPTY && age >= cache_to_q) begin
					e_st = ST_EMPTY;
				end
				if (e_st == ST_SENT && age >= reply_to_q) begin
					if (rd_tries < max_att_q) begin
						e_st = ST_WANT;
						e_stamp = cmd_q.now;
						e_tries = rd_tries + 3'd1;
					end else begin
						e_st = ST_EMPTY;
					end
				end
				if (!cmd_q.busy && e_st == ST_WANT) begin
					e_st = ST_SENT;
					e_stamp = cmd_q.now;
					e_res.send_request = 1'b1;
					e_res.addr_high_out = rd_hi;
					e_res.addr_low_out = rd_lo;
				end
			end
			ACT_READ: begin
				if (idx_ok) begin
					e_res.mac_out = rd_mac;
					e_res.index_out = cmd_q.idx;
					e_res.state_out = s;
					e_res.age_out = age;
					e_res.addr_high_out = rd_hi;
					e_res.addr_low_out = rd_lo;
				end
			end
			default: ;
		endcase
		if (req && !blank_req) begin
			e_res.index_out = 5'(tgt_q);
			if (!hit_q || age >= freeze_to_q) begin
				e_we = 1'b1;
				e_st = ST_WANT;
				e_tries = 3'd0;
				e_stamp = cmd_q.now;
				if (!hit_q) begin
					e_hi = cmd_q.ip_high;
					e_lo = cmd_q.ip_low;
					e_mac = '0;
				end
			end
		end
	end

	assign ram_we = (st_q == S_EXEC) && e_we;
	assign ram_wa = tgt_q;
	assign ram_wd = {e_hi, e_lo, e_mac, e_tries, e_stamp};

	assign q_ready = (st_q == S_IDLE) && !rv_q;
	assign r_valid = rv_q;
	assign r_res = res_q;

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && q_valid && !rv_q) begin
			cmd_q <= q_cmd;
		end
		if (st_q == S_SCAN && k_q == ENT_C && !kv_q) begin
			tgt_q <= tgt_d;
		end
		if (st_q == S_EXEC) begin
			res_q <= e_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rv_q <= 1'b0;
			sp_q <= LAST;
			k_q <= '0;
			kd_q <= '0;
			kv_q <= 1'b0;
			hit_q <= 1'b0;
			hitv_q <= 1'b0;
			hidx_q <= '0;
			vhidx_q <= '0;
			emp_q <= 1'b0;
			eidx_q <= '0;
			bage_q <= '0;
			bidx_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				est_q[i] <= ST_EMPTY;
			end
		end else begin
			st_q <= st_d;
			if (rv_q && r_ready) begin
				rv_q <= 1'b0;
			end
			if (st_q == S_IDLE) begin
				k_q <= '0;
				kv_q <= 1'b0;
				hit_q <= 1'b0;
				hitv_q <= 1'b0;
				emp_q <= 1'b0;
				bage_q <= '0;
				bidx_q <= '0;
			end
			if (use_scan) begin
				kv_q <= (k_q != ENT_C);
				kd_q <= k_q[IW-1:0];
				if (k_q != ENT_C) begin
					k_q <= k_q + 1'b1;
				end
				if (kv_q) begin
					if (ks != ST_EMPTY && amatch && !hit_q) begin
						hit_q <= 1'b1;
						hidx_q <= kd_q;
					end
					if (ks == ST_VALID && amatch && !hitv_q) begin
						hitv_q <= 1'b1;
						vhidx_q <= kd_q;
					end
					if (ks == ST_EMPTY && !emp_q) begin
						emp_q <= 1'b1;
						eidx_q <= kd_q;
					end
					if (ks != ST_EMPTY && kage >= bage_q) begin
						bage_q <= kage;
						bidx_q <= kd_q;
					end
				end
			end
			if (st_q == S_EXEC) begin
				if (e_we) begin
					est_q[tgt_q] <= e_st;
				end
				if (e_sp) begin
					sp_q <= tgt_q;
				end
			end
			if (st_q == S_OUT) begin
				rv_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_one_res: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT) |-> !rv_q) else $error("result overwritten");
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RD) |-> (k_q == ENT_C)) else $error("scan cut short");
	a_send: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && res_q.send_request) |-> (cmd_q.act == ACT_SERVICE))
		else $error("send outside service");
	a_sp: assert property (@(posedge clk) disable iff (!arst_n)
		{{(32-IW){1'b0}}, sp_q} < 32'(ENTRIES)) else $error("pointer out of range");
`endif

endmodule

// ===== bench/ipv6_neighbor_cache_test.sv =====
`timescale 1ns / 100ps

module ipv6_neighbor_cache_test;
	import nc_pkg::*;

	localparam int NREC = ENTRIES_DEF;
	localparam int RAND_ITEMS = 1250;
	localparam int PHASES = 6;
	localparam int LIMIT = 3000000;
	localparam int DRAIN = 80;

	typedef struct {
		act_t        act;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [47:0] mac;
		logic [4:0]  idx;
		logic [31:0] now;
		logic        busy;
	} item_t;

	typedef struct {
		item_t item;
		logic  typed;
		res_t  want;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [223:0] m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_idx;
	logic [31:0]  cfg_data;

	// neighbor table mirror
	logic [63:0] nb_hi [NREC];
	logic [63:0] nb_lo [NREC];
	logic [47:0] nb_mac [NREC];
	est_t        nb_st [NREC];
	logic [2:0]  nb_tries [NREC];
	logic [31:0] nb_stamp [NREC];
	bit          nb_written [NREC];
	int          svc_ptr;
	logic [31:0] cache_to, freeze_to, reply_to;
	logic [2:0]  max_att;

	res_t        pending_results[$];
	int          errors;
	int          cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          n_results;
	int          n_hits;
	int          n_sends;
	int          n_rejects;
	int          n_act [8];
	logic [63:0] pool_hi [16];
	logic [63:0] pool_lo [16];
	logic [31:0] clock_ms;

	ipv6_neighbor_cache dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic bit blank_addr(logic [63:0] hi);
		return hi[63:56] == 8'd0;
	endfunction

	function automatic int find_rec(logic [63:0] hi, logic [63:0] lo, bit valid_only);
		for (int k = 0; k < NREC; k++)
			if (nb_st[k] != ST_EMPTY && (!valid_only || nb_st[k] == ST_VALID) &&
			    nb_hi[k] == hi && nb_lo[k] == lo)
				return k;
		return -1;
	endfunction

	function automatic int pick_victim(logic [31:0] now);
		int best;
		logic [31:0] best_age;
		logic [31:0] age;
		best = 0;
		best_age = 0;
		for (int k = 0; k < NREC; k++) begin
			if (nb_st[k] == ST_EMPTY)
				return k;
			age = now - nb_stamp[k];
			if (age >= best_age) begin
				best_age = age;
				best = k;
			end
		end
		return best;
	endfunction

	function automatic int request_rec(logic [63:0] hi, logic [63:0] lo, logic [31:0] now);
		int k;
		if (blank_addr(hi))
			return -1;
		k = find_rec(hi, lo, 1'b0);
		if (k >= 0) begin
			if (now - nb_stamp[k] < freeze_to)
				return k;
		end else begin
			k = pick_victim(now);
			nb_hi[k] = hi;
			nb_lo[k] = lo;
			nb_mac[k] = '0;
			nb_written[k] = 1'b1;
		end
		nb_st[k] = ST_WANT;
		nb_tries[k] = '0;
		nb_stamp[k] = now;
		return k;
	endfunction

	function automatic res_t predict_neighbor(item_t it);
		res_t r;
		int k;
		r = '0;
		case (it.act)
			ACT_LOOKUP, ACT_CHECK: begin
				k = find_rec(it.hi, it.lo, 1'b1);
				if (k >= 0) begin
					r.found = 1'b1;
					r.mac_out = nb_mac[k];
					r.index_out = k[4:0];
				end else if (it.act == ACT_CHECK) begin
					k = request_rec(it.hi, it.lo, it.now);
					if (k >= 0)
						r.index_out = k[4:0];
				end
			end
			ACT_REQUEST: begin
				k = request_rec(it.hi, it.lo, it.now);
				if (k >= 0)
					r.index_out = k[4:0];
			end
			ACT_ADD: begin
				if (blank_addr(it.hi) || it.mac == '0) begin
					r.status = 1'b1;
				end else begin
					k = find_rec(it.hi, it.lo, 1'b0);
					if (k < 0) begin
						k = pick_victim(it.now);
						nb_hi[k] = it.hi;
						nb_lo[k] = it.lo;
						nb_written[k] = 1'b1;
					end
					nb_mac[k] = it.mac;
					nb_stamp[k] = it.now;
					nb_st[k] = ST_VALID;
					r.index_out = k[4:0];
				end
			end
			ACT_SERVICE: begin
				svc_ptr = (svc_ptr + 1) % NREC;
				k = svc_ptr;
				r.index_out = k[4:0];
				if (nb_st[k] != ST_EMPTY && it.now - nb_stamp[k] >= cache_to)
					nb_st[k] = ST_EMPTY;
				if (nb_st[k] == ST_SENT && it.now - nb_stamp[k] >= reply_to) begin
					if (nb_tries[k] < max_att) begin
						nb_st[k] = ST_WANT;
						nb_stamp[k] = it.now;
						nb_tries[k] = nb_tries[k] + 3'd1;
					end else begin
						nb_st[k] = ST_EMPTY;
					end
				end
				if (!it.busy && nb_st[k] == ST_WANT) begin
					nb_st[k] = ST_SENT;
					nb_stamp[k] = it.now;
					r.send_request = 1'b1;
					r.addr_high_out = nb_hi[k];
					r.addr_low_out = nb_lo[k];
				end
			end
			ACT_READ: begin
				k = int'(it.idx);
				r.mac_out = nb_mac[k];
				r.index_out = it.idx;
				r.state_out = nb_st[k];
				r.age_out = it.now - nb_stamp[k];
				r.addr_high_out = nb_hi[k];
				r.addr_low_out = nb_lo[k];
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic res_t unpack_result(logic [223:0] d);
		res_t r;
		r.status = d[0];
		r.found = d[1];
		r.mac_out = d[49:2];
		r.index_out = d[54:50];
		r.state_out = d[56:55];
		r.age_out = d[88:57];
		r.send_request = d[89];
		r.addr_high_out = d[153:90];
		r.addr_low_out = d[217:154];
		return r;
	endfunction

	task automatic compare_result(res_t exp_r, res_t got);
		logic [63:0] ev [9];
		logic [63:0] gv [9];
		string names [9];
		names = '{"status", "found", "mac_out", "index_out", "state_out", "age_out",
			"send_request", "addr_high_out", "addr_low_out"};
		ev = '{exp_r.status, exp_r.found, exp_r.mac_out, exp_r.index_out, exp_r.state_out,
			exp_r.age_out, exp_r.send_request, exp_r.addr_high_out, exp_r.addr_low_out};
		gv = '{got.status, got.found, got.mac_out, got.index_out, got.state_out,
			got.age_out, got.send_request, got.addr_high_out, got.addr_low_out};
		for (int f = 0; f < 9; f++)
			if (ev[f] !== gv[f]) begin
				$display("%0t: %s mismatch expected %h actual %h", $time, names[f], ev[f], gv[f]);
				errors++;
			end
	endtask

	// result side
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word expected none actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				compare_result(pending_results.pop_front(), unpack_result(m_axis_tdata));
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL ipv6_neighbor_cache");
			$finish;
		end
	end

	task automatic send_word(item_t it, bit typed, res_t typed_res);
		res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, it.busy, it.now, it.idx, it.mac, it.lo, it.hi, it.act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = predict_neighbor(it);
		if (r.found)
			n_hits++;
		if (r.send_request)
			n_sends++;
		if (r.status)
			n_rejects++;
		n_act[it.act]++;
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic write_reg(reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CACHE: cache_to = val;
			REG_FREEZE: freeze_to = val;
			REG_REPLY: reply_to = val;
			default: max_att = val[2:0];
		endcase
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t random_item();
		item_t it;
		int roll;
		int p;
		int cand [$];
		roll = $urandom_range(99);
		it.act = roll < 15 ? ACT_LOOKUP : roll < 35 ? ACT_REQUEST : roll < 50 ? ACT_CHECK :
			roll < 70 ? ACT_ADD : roll < 88 ? ACT_SERVICE : roll < 97 ? ACT_READ :
			roll < 98 ? ACT_NOP6 : ACT_NOP7;
		p = $urandom_range(15);
		it.hi = pool_hi[p];
		it.lo = pool_lo[p];
		roll = $urandom_range(99);
		if (roll < 5) begin
			it.hi = rand64();
			it.lo = rand64();
		end else if (roll < 10) begin
			it.hi[63:56] = 8'd0;
		end
		it.mac = ($urandom_range(99) < 5) ? 48'd0 : 48'(rand64());
		it.idx = 5'($urandom);
		it.busy = ($urandom_range(99) < 30);
		clock_ms = clock_ms + (($urandom_range(99) < 3) ? $urandom : $urandom_range(40));
		it.now = clock_ms;
		if (it.act == ACT_READ) begin
			for (int k = 0; k < NREC; k++)
				if (nb_written[k])
					cand.push_back(k);
			if (cand.size() == 0)
				it.act = ACT_LOOKUP;
			else
				it.idx = 5'(cand[$urandom_range(cand.size() - 1)]);
		end
		return it;
	endfunction

	function automatic row_t mk(act_t a, logic [63:0] hi, logic [63:0] lo, logic [47:0] mac,
			logic [4:0] idx, logic [31:0] now, logic busy, logic typed, res_t want);
		row_t r;
		r.item = '{a, hi, lo, mac, idx, now, busy};
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	initial begin
		row_t rows [$];
		res_t zero_res;
		res_t reject;
		logic [63:0] a_hi, b_hi, c_hi, blank_hi;
		logic [31:0] cfg_set [PHASES][4];
		int per_phase;

		errors = 0;
		cycles = 0;
		n_results = 0;
		n_hits = 0;
		n_sends = 0;
		n_rejects = 0;
		n_act = '{default: 0};
		send_idle_pct = 35;
		recv_idle_pct = 84;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_CACHE;
		cfg_data = '0;
		for (int k = 0; k < NREC; k++) begin
			nb_st[k] = ST_EMPTY;
			nb_written[k] = 1'b0;
			nb_hi[k] = '0;
			nb_lo[k] = '0;
			nb_mac[k] = '0;
			nb_tries[k] = '0;
			nb_stamp[k] = '0;
		end
		svc_ptr = NREC - 1;
		cache_to = CACHE_TO_RST;
		freeze_to = FREEZE_TO_RST;
		reply_to = REPLY_TO_RST;
		max_att = MAX_ATT_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		zero_res = '0;
		reject = '0;
		reject.status = 1'b1;
		a_hi = 64'hFE80_0000_0000_0001;
		b_hi = '1;
		c_hi = 64'h0100_0000_0000_0000;
		blank_hi = 64'h00FF_FFFF_FFFF_FFFF;
		rows.push_back(mk(ACT_LOOKUP, a_hi, 64'd1, 48'd0, 5'd0, 32'd0, 1'b0, 1'b1, zero_res));
		rows.push_back(mk(ACT_ADD, a_hi, 64'd1, 48'd0, 5'd0, 32'd0, 1'b0, 1'b1, reject));
		rows.push_back(mk(ACT_ADD, blank_hi, '1, '1, 5'd31, 32'd0, 1'b1, 1'b1, reject));
		rows.push_back(mk(ACT_REQUEST, blank_hi, '1, '1, 5'd31, '1, 1'b1, 1'b1, zero_res));
		rows.push_back(mk(ACT_NOP6, b_hi, '1, '1, 5'd31, '1, 1'b1, 1'b1, zero_res));
		rows.push_back(mk(ACT_NOP7, a_hi, 64'd1, 48'd5, 5'd0, 32'd0, 1'b0, 1'b1, zero_res));
		rows.push_back(mk(ACT_ADD, a_hi, 64'd1, '1, 5'd0, 32'd0, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_LOOKUP, a_hi, 64'd1, 48'd0, 5'd0, 32'd3, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_READ, 64'd0, 64'd0, 48'd0, 5'd0, 32'd7, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_REQUEST, b_hi, '1, 48'd0, 5'd0, 32'd10, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_CHECK, c_hi, 64'd0, 48'd0, 5'd0, 32'd20, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_SERVICE, 64'd0, 64'd0, 48'd0, 5'd0, 32'd30, 1'b1, 1'b0, zero_res));
		rows.push_back(mk(ACT_SERVICE, 64'd0, 64'd0, 48'd0, 5'd0, 32'd40, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_SERVICE, 64'd0, 64'd0, 48'd0, 5'd0, 32'd50, 1'b1, 1'b0, zero_res));
		rows.push_back(mk(ACT_READ, 64'd0, 64'd0, 48'd0, 5'd1, 32'd60, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_READ, 64'd0, 64'd0, 48'd0, 5'd2, '1, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_REQUEST, b_hi, '1, 48'd0, 5'd0, 32'd70, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_CHECK, a_hi, 64'd1, 48'd0, 5'd0, 32'd80, 1'b0, 1'b0, zero_res));
		rows.push_back(mk(ACT_ADD, b_hi, '1, 48'h0000_0000_0001, 5'd0, 32'd90, 1'b0, 1'b0,
			zero_res));
		rows.push_back(mk(ACT_SERVICE, 64'd0, 64'd0, 48'd0, 5'd0, 32'd5000, 1'b0, 1'b0,
			zero_res));
		rows.push_back(mk(ACT_READ, 64'd0, 64'd0, 48'd0, 5'd1, 32'd5001, 1'b0, 1'b0, zero_res));
		foreach (rows[i])
			send_word(rows[i].item, rows[i].typed, rows[i].want);
		drain();

		// cache, freeze, reply, max attempts
		cfg_set = '{
			'{CACHE_TO_RST, FREEZE_TO_RST, REPLY_TO_RST, 32'(MAX_ATT_RST)},
			'{32'd1, 32'd0, 32'd1, 32'd0},
			'{32'd3000, 32'd200, 32'd60, 32'd7},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7},
			'{32'd800, 32'd0, 32'd15, 32'd2},
			'{32'd20000, 32'd400, 32'd100, 32'd5}};
		per_phase = RAND_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_CACHE, cfg_set[ph][0]);
			write_reg(REG_FREEZE, cfg_set[ph][1]);
			write_reg(REG_REPLY, cfg_set[ph][2]);
			write_reg(REG_MAXATT, cfg_set[ph][3]);
			case (ph * 3 / PHASES)
				0: begin send_idle_pct = 35; recv_idle_pct = 84; end
				1: begin send_idle_pct = 84; recv_idle_pct = 35; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			clock_ms = (ph == 3) ? 32'hFFFF_F000 : $urandom;
			for (int p = 0; p < 16; p++) begin
				pool_hi[p] = rand64();
				pool_hi[p][63:56] = pool_hi[p][63:56] | 8'h01;
				pool_lo[p] = rand64();
			end
			for (int i = 0; i < per_phase; i++) begin
				send_word(random_item(), 1'b0, zero_res);
				if (i == per_phase / 2) begin
					// hold off until every outstanding word is back
					s_axis_tvalid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("covered %0d words: lookup %0d request %0d check %0d add %0d service %0d",
			n_results, n_act[ACT_LOOKUP], n_act[ACT_REQUEST], n_act[ACT_CHECK],
			n_act[ACT_ADD], n_act[ACT_SERVICE]);
		$display("read %0d, hits %0d, resolve requests %0d, rejected adds %0d, %0d settings",
			n_act[ACT_READ], n_hits, n_sends, n_rejects, PHASES);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS ipv6_neighbor_cache");
		end else begin
			$display("FAIL ipv6_neighbor_cache");
		end
		$finish;
	end

endmodule
